FILE: hw/rtl/gtuv_pkg.sv
// ============================================================================
// gtuv_pkg
// Shared widths, types, register indexes and helpers of the grid triangle
// UV mapper.
// ============================================================================
package gtuv_pkg;

   localparam int COORD_BITS   = 24;
   localparam int DIFF_BITS    = COORD_BITS + 1;
   localparam int SQ_BITS      = 2 * COORD_BITS + 1;
   localparam int DIST_BITS    = SQ_BITS + 1;
   localparam int UV_FRAC_BITS = 16;
   localparam int UV_BITS      = UV_FRAC_BITS + 1;
   localparam int HALF_UV_BITS = UV_FRAC_BITS;
   localparam int QPL_BITS     = 11;
   localparam int ROW_BITS     = 11;
   localparam int HALF_BITS    = 12;
   localparam int PROD_BITS    = UV_BITS + QPL_BITS;
   localparam int CORNER_BITS  = UV_BITS + 2;
   localparam int INV_BITS     = 24;
   localparam int BS_PROD_BITS = UV_BITS + INV_BITS;
   localparam int CSR_IDX_BITS = 2;

   localparam logic [QPL_BITS-1:0] MAX_QUADS     = QPL_BITS'(1024);
   localparam logic [INV_BITS-1:0] INV_SQRT2_Q24 = INV_BITS'(11863283);

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef coord_type [2:0]              vertex_type;
   typedef logic [UV_BITS-1:0]           uv_type;
   typedef logic [HALF_UV_BITS-1:0]      inset_type;
   typedef logic [1:0]                   edge_type;

   localparam uv_type UV_ONE  = uv_type'(1 << UV_FRAC_BITS);
   localparam uv_type UV_ZERO = '0;

   localparam edge_type EDGE_01 = 2'd0;
   localparam edge_type EDGE_12 = 2'd1;
   localparam edge_type EDGE_20 = 2'd2;

   localparam logic [CSR_IDX_BITS-1:0] CSR_QUADS_PER_LINE = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CELL_SIZE_UV   = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_BORDER_UV      = 2'd2;

   localparam logic [QPL_BITS-1:0] QPL_RESET    = QPL_BITS'(1);
   localparam uv_type              CELL_RESET   = UV_ONE;
   localparam uv_type              BORDER_RESET = uv_type'(64);

   typedef struct packed {
      uv_type u;
      uv_type v;
   } wedge_type;

   typedef struct packed {
      uv_type left;
      uv_type right;
      uv_type bottom;
      uv_type top;
      logic   upper;
      logic   assigned;
   } place_type;

   // border over sqrt(2), rounded
   function automatic uv_type border_bs(input uv_type border);
      logic [BS_PROD_BITS-1:0] p;
      p = BS_PROD_BITS'(border) * BS_PROD_BITS'(INV_SQRT2_Q24)
          + BS_PROD_BITS'(1 << (INV_BITS - 1));
      return p[INV_BITS +: UV_BITS];
   endfunction

endpackage

FILE: hw/rtl/grid_triangle_uv_mapper_core.sv
// ============================================================================
// grid_triangle_uv_mapper_core
// Places each non-deleted mesh triangle, while rows remain, as the next half
// of a grid quad and returns its three UV corners, longest edge first.
// ============================================================================
//  channel  | ports                         | transfer
//  ---------+-------------------------------+------------------------------
//  request  | req_valid, req_stall, req_*   | valid high, stall low
//  response | rsp_valid, rsp_stall, rsp_*   | valid high, stall low
//  csr      | csr_wen, csr_index, csr_wdata | wen high
//
//  One triangle per cycle while rsp_stall is low; a response passes through the
//  input register, squares and grid cell register, output register.
//  Reset clears the valid bits and the grid walk and loads the csr defaults.
//  Empty stages close up under rsp_stall; req_stall rises only when every
//  stage holds a triangle.
module grid_triangle_uv_mapper_core (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  gtuv_pkg::coord_type                   req_vertex0_x,
   input  gtuv_pkg::coord_type                   req_vertex0_y,
   input  gtuv_pkg::coord_type                   req_vertex0_z,
   input  gtuv_pkg::coord_type                   req_vertex1_x,
   input  gtuv_pkg::coord_type                   req_vertex1_y,
   input  gtuv_pkg::coord_type                   req_vertex1_z,
   input  gtuv_pkg::coord_type                   req_vertex2_x,
   input  gtuv_pkg::coord_type                   req_vertex2_y,
   input  gtuv_pkg::coord_type                   req_vertex2_z,
   input  logic                                  req_face_deleted,
   input  logic                                  req_restart,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output gtuv_pkg::uv_type                      rsp_wedge0_u,
   output gtuv_pkg::uv_type                      rsp_wedge0_v,
   output gtuv_pkg::uv_type                      rsp_wedge1_u,
   output gtuv_pkg::uv_type                      rsp_wedge1_v,
   output gtuv_pkg::uv_type                      rsp_wedge2_u,
   output gtuv_pkg::uv_type                      rsp_wedge2_v,
   output logic                                  rsp_assigned,
   input  logic                                  csr_wen,
   input  logic [gtuv_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  gtuv_pkg::uv_type                      csr_wdata
);
   import gtuv_pkg::*;

   logic [QPL_BITS-1:0] qpl_ff;
   uv_type              cell_ff;
   uv_type              border_ff;
   uv_type              bs_ff;
   inset_type           hb;

   logic                v1_ff, v2_ff, vo_ff;
   logic                load1, load2, load_o;
   vertex_type [2:0]    vtx_ff;
   logic                deleted_ff, restart_ff;
   place_type           place;
   edge_type            longest;
   wedge_type [2:0]     wedge_in;
   wedge_type [2:0]     wedge_ff;
   logic                assigned_ff;

   // csr registers
   always_ff @(posedge clock) begin
      if (reset) begin
         qpl_ff    <= QPL_RESET;
         cell_ff   <= CELL_RESET;
         border_ff <= BORDER_RESET;
         bs_ff     <= border_bs(BORDER_RESET);
      end else if (csr_wen) begin
         case (csr_index)
            CSR_QUADS_PER_LINE: qpl_ff <= csr_wdata[QPL_BITS-1:0];
            CSR_CELL_SIZE_UV:   cell_ff <= csr_wdata;
            CSR_BORDER_UV: begin
               border_ff <= csr_wdata;
               bs_ff     <= border_bs(csr_wdata);
            end
            default: ;
         endcase
      end
   end

   assign hb = border_ff[UV_BITS-1:1];

   // advance when the next stage is empty or moving
   assign load_o    = !vo_ff || !rsp_stall;
   assign load2     = !v2_ff || load_o;
   assign load1     = !v1_ff || load2;
   assign req_stall = !load1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (load1) begin
            v1_ff <= req_valid;
         end
         if (load2) begin
            v2_ff <= v1_ff;
         end
         if (load_o) begin
            vo_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load1) begin
         vtx_ff[0]  <= {req_vertex0_z, req_vertex0_y, req_vertex0_x};
         vtx_ff[1]  <= {req_vertex1_z, req_vertex1_y, req_vertex1_x};
         vtx_ff[2]  <= {req_vertex2_z, req_vertex2_y, req_vertex2_x};
         deleted_ff <= req_face_deleted;
         restart_ff <= req_restart;
      end
   end

   gtuv_edge u_edge (
      .clock   (clock),
      .load    (load2),
      .vtx     (vtx_ff),
      .longest (longest)
   );

   gtuv_place u_place (
      .clock          (clock),
      .reset          (reset),
      .load           (load2),
      .item_valid     (v1_ff),
      .deleted        (deleted_ff),
      .restart        (restart_ff),
      .quads_per_line (qpl_ff),
      .cell_size      (cell_ff),
      .place          (place)
   );

   gtuv_wedge u_wedge (
      .place   (place),
      .hb      (hb),
      .bs      (bs_ff),
      .longest (longest),
      .wedge   (wedge_in)
   );

   always_ff @(posedge clock) begin
      if (load_o) begin
         wedge_ff    <= wedge_in;
         assigned_ff <= place.assigned;
      end
   end

   assign rsp_valid    = vo_ff;
   assign rsp_wedge0_u = wedge_ff[0].u;
   assign rsp_wedge0_v = wedge_ff[0].v;
   assign rsp_wedge1_u = wedge_ff[1].u;
   assign rsp_wedge1_v = wedge_ff[1].v;
   assign rsp_wedge2_u = wedge_ff[2].u;
   assign rsp_wedge2_v = wedge_ff[2].v;
   assign rsp_assigned = assigned_ff;

endmodule

FILE: hw/rtl/gtuv_edge.sv
// ============================================================================
// gtuv_edge
// Squared edge lengths of one triangle, registered, and the longest edge.
// ============================================================================
module gtuv_edge (
   input  logic                          clock,
   input  logic                          load,
   input  gtuv_pkg::vertex_type [2:0]    vtx,
   output gtuv_pkg::edge_type            longest
);
   import gtuv_pkg::*;

   logic [DIFF_BITS-1:0]   diff [3][3];
   logic signed [2*DIFF_BITS-1:0] prod [3][3];
   logic [SQ_BITS-1:0]     sq_in [3][3];
   logic [SQ_BITS-1:0]     sq_ff [3][3];
   logic [DIST_BITS-1:0]   len_sq [3];
   logic                   gt01_12;
   logic                   gt01_20;
   logic                   gt12_20;

   always_comb begin
      int n;
      for (int e = 0; e < 3; e++) begin
         n = (e == 2) ? 0 : e + 1;
         for (int c = 0; c < 3; c++) begin
            diff[e][c] = {vtx[e][c][COORD_BITS-1], vtx[e][c]}
                       - {vtx[n][c][COORD_BITS-1], vtx[n][c]};
            prod[e][c] = $signed(diff[e][c]) * $signed(diff[e][c]);
            sq_in[e][c] = prod[e][c][SQ_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         sq_ff <= sq_in;
      end
   end

   always_comb begin
      for (int e = 0; e < 3; e++) begin
         len_sq[e] = DIST_BITS'(sq_ff[e][0]) + DIST_BITS'(sq_ff[e][1])
                   + DIST_BITS'(sq_ff[e][2]);
      end
   end

   assign gt01_12 = len_sq[0] > len_sq[1];
   assign gt01_20 = len_sq[0] > len_sq[2];
   assign gt12_20 = len_sq[1] > len_sq[2];

   always_comb begin
      if (gt01_12) begin
         longest = gt01_20 ? EDGE_01 : EDGE_20;
      end else begin
         longest = gt12_20 ? EDGE_12 : EDGE_20;
      end
   end

endmodule

FILE: hw/rtl/gtuv_place.sv
// ============================================================================
// gtuv_place
// Grid walk state: picks the quad half of each face and registers its cell.
// ============================================================================
module gtuv_place (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic                            item_valid,
   input  logic                            deleted,
   input  logic                            restart,
   input  logic [gtuv_pkg::QPL_BITS-1:0]   quads_per_line,
   input  gtuv_pkg::uv_type                cell_size,
   output gtuv_pkg::place_type             place
);
   import gtuv_pkg::*;

   logic [ROW_BITS-1:0]  row_ff, row_in, cur_row, row_n;
   logic [HALF_BITS-1:0] half_ff, half_in, cur_half;
   logic [HALF_BITS:0]   half_inc;
   logic [QPL_BITS-1:0]  half_q;
   logic                 upper_ff, upper_in, cur_upper;
   uv_type               left_ff, left_in, cur_left;
   uv_type               right_ff, right_in, cur_right;
   uv_type               bottom_ff, bottom_in, cur_bottom;
   uv_type               top_ff, top_in, cur_top;
   logic [QPL_BITS-1:0]  q;
   logic                 full, place_ok, new_row, wrap;
   logic [PROD_BITS-1:0] prod_v, prod_u;
   uv_type               right_a, left_new, right_new, bottom_new, top_new;
   place_type            place_ff, place_in;

   function automatic uv_type sat_uv(input logic [PROD_BITS-1:0] p);
      if (p > PROD_BITS'(UV_ONE)) begin
         return UV_ONE;
      end
      return p[UV_BITS-1:0];
   endfunction

   always_comb begin
      if (restart) begin
         cur_row    = '0;
         cur_half   = '0;
         cur_upper  = 1'b1;
         cur_left   = UV_ZERO;
         cur_right  = UV_ZERO;
         cur_bottom = UV_ONE;
         cur_top    = UV_ONE;
      end else begin
         cur_row    = row_ff;
         cur_half   = half_ff;
         cur_upper  = upper_ff;
         cur_left   = left_ff;
         cur_right  = right_ff;
         cur_bottom = bottom_ff;
         cur_top    = top_ff;
      end

      q        = (quads_per_line > MAX_QUADS) ? MAX_QUADS : quads_per_line;
      full     = cur_row >= q;
      place_ok = !deleted && !full;
      new_row  = cur_half == '0;

      row_n  = cur_row + ROW_BITS'(1);
      half_q = QPL_BITS'(cur_half[HALF_BITS-1:1]) + QPL_BITS'(1);
      prod_v = PROD_BITS'(cell_size) * PROD_BITS'(row_n);
      prod_u = PROD_BITS'(cell_size) * PROD_BITS'(half_q);

      top_new    = new_row ? cur_bottom : cur_top;
      right_a    = new_row ? UV_ZERO : cur_right;
      bottom_new = new_row ? (UV_ONE - sat_uv(prod_v)) : cur_bottom;
      left_new   = cur_upper ? right_a : cur_left;
      right_new  = cur_upper ? sat_uv(prod_u) : right_a;

      half_inc = {1'b0, cur_half} + (HALF_BITS+1)'(1);
      wrap     = half_inc >= (HALF_BITS+1)'({q, 1'b0});

      if (place_ok) begin
         left_in   = left_new;
         right_in  = right_new;
         bottom_in = bottom_new;
         top_in    = top_new;
         upper_in  = !cur_upper;
         half_in   = wrap ? '0 : half_inc[HALF_BITS-1:0];
         row_in    = wrap ? row_n : cur_row;
      end else begin
         left_in   = cur_left;
         right_in  = cur_right;
         bottom_in = cur_bottom;
         top_in    = cur_top;
         upper_in  = cur_upper;
         half_in   = cur_half;
         row_in    = cur_row;
      end

      place_in.left     = left_new;
      place_in.right    = right_new;
      place_in.bottom   = bottom_new;
      place_in.top      = top_new;
      place_in.upper    = cur_upper;
      place_in.assigned = place_ok;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff    <= '0;
         half_ff   <= '0;
         upper_ff  <= 1'b1;
         left_ff   <= UV_ZERO;
         right_ff  <= UV_ZERO;
         bottom_ff <= UV_ONE;
         top_ff    <= UV_ONE;
      end else if (load && item_valid) begin
         row_ff    <= row_in;
         half_ff   <= half_in;
         upper_ff  <= upper_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         bottom_ff <= bottom_in;
         top_ff    <= top_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         place_ff <= place_in;
      end
   end

   assign place = place_ff;

endmodule

FILE: hw/rtl/gtuv_wedge.sv
// ============================================================================
// gtuv_wedge
// Inset corners of the placed half, clamp, and rotate onto the wedges.
// ============================================================================
module gtuv_wedge (
   input  gtuv_pkg::place_type        place,
   input  gtuv_pkg::inset_type        hb,
   input  gtuv_pkg::uv_type           bs,
   input  gtuv_pkg::edge_type         longest,
   output gtuv_pkg::wedge_type [2:0]  wedge
);
   import gtuv_pkg::*;

   logic signed [CORNER_BITS-1:0] hb_s, bsu_s, bsl_s;
   logic signed [CORNER_BITS-1:0] blu, blv, tru, trv;
   wedge_type [2:0]               corner;

   function automatic logic signed [CORNER_BITS-1:0] ext_uv(input uv_type x);
      return $signed({2'b00, x});
   endfunction

   function automatic uv_type clamp_uv(input logic signed [CORNER_BITS-1:0] x);
      if (x < 0) begin
         return UV_ZERO;
      end
      if (x > ext_uv(UV_ONE)) begin
         return UV_ONE;
      end
      return x[UV_BITS-1:0];
   endfunction

   always_comb begin
      hb_s  = $signed({3'b000, hb});
      bsu_s = place.upper ? $signed({2'b00, bs}) : '0;
      bsl_s = place.upper ? '0 : $signed({2'b00, bs});

      blu = ext_uv(place.left) + hb_s + bsl_s;
      blv = ext_uv(place.bottom) + hb_s + bsu_s;
      tru = ext_uv(place.right) - hb_s - bsu_s;
      trv = ext_uv(place.top) - hb_s - bsl_s;

      if (place.upper) begin
         corner[0].u = clamp_uv(blu);
         corner[0].v = clamp_uv(blv);
         corner[1].u = clamp_uv(tru);
         corner[1].v = clamp_uv(trv);
         corner[2].u = clamp_uv(blu);
         corner[2].v = clamp_uv(trv);
      end else begin
         corner[0].u = clamp_uv(tru);
         corner[0].v = clamp_uv(trv);
         corner[1].u = clamp_uv(blu);
         corner[1].v = clamp_uv(blv);
         corner[2].u = clamp_uv(tru);
         corner[2].v = clamp_uv(blv);
      end

      // start the corner list at the longest edge
      case (longest)
         EDGE_01: begin
            wedge[0] = corner[0];
            wedge[1] = corner[1];
            wedge[2] = corner[2];
         end
         EDGE_12: begin
            wedge[1] = corner[0];
            wedge[2] = corner[1];
            wedge[0] = corner[2];
         end
         EDGE_20: begin
            wedge[2] = corner[0];
            wedge[0] = corner[1];
            wedge[1] = corner[2];
         end
         default: begin
            wedge[0] = corner[0];
            wedge[1] = corner[1];
            wedge[2] = corner[2];
         end
      endcase

      if (!place.assigned) begin
         wedge = '0;
      end
   end

endmodule
